### design/ilb_pkg.sv
package ilb_pkg;

   // List geometry.
   localparam int CAPACITY   = 64;
   localparam int WORD_BITS  = 32;
   localparam int IDX_BITS   = $clog2(CAPACITY);
   localparam int COUNT_BITS = $clog2(CAPACITY + 1);

   // Command codes carried by an input item.
   typedef enum logic [2:0] {
      CMD_PUSH   = 3'd0,
      CMD_POP    = 3'd1,
      CMD_CLEAR  = 3'd2,
      CMD_INSERT = 3'd3,
      CMD_ERASE  = 3'd4,
      CMD_READ   = 3'd5
   } cmd_type;

   // Status codes returned with every result item.
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   // Input item.
   typedef struct packed {
      cmd_type               command;
      logic [IDX_BITS-1:0]   position;
      logic [WORD_BITS-1:0]  item_value;
   } req_type;

   // Result item.
   typedef struct packed {
      logic [WORD_BITS-1:0]  read_value;
      logic [COUNT_BITS-1:0] entry_count;
      status_type            status;
   } rsp_type;

   // Shift control broadcast to every cell of the row.
   typedef struct packed {
      logic                  insert_en;
      logic                  erase_en;
      logic [IDX_BITS-1:0]   pos;
      logic [COUNT_BITS-1:0] count;
      logic [WORD_BITS-1:0]  value;
   } shift_type;

endpackage

### design/ilb_cell.sv
module ilb_cell import ilb_pkg::*; (
   input  logic                 clock,
   input  logic [IDX_BITS-1:0]  cell_index,
   input  shift_type            shift,
   input  logic [WORD_BITS-1:0] lower_word,
   input  logic [WORD_BITS-1:0] upper_word,
   output logic [WORD_BITS-1:0] word,
   output logic [WORD_BITS-1:0] read_word
);

   logic [WORD_BITS-1:0]  word_ff;
   logic [WORD_BITS-1:0]  word_in;
   logic [COUNT_BITS-1:0] index_wide;
   logic                  at_pos;
   logic                  take_lower;
   logic                  take_upper;

   assign index_wide = COUNT_BITS'(cell_index);
   assign at_pos     = (cell_index == shift.pos);

   // On insert, cells above the position up to the old end take their lower neighbor.
   assign take_lower = shift.insert_en && (cell_index > shift.pos) && (index_wide <= shift.count);

   // On erase, cells from the position up to one below the old last entry take their upper neighbor.
   assign take_upper = shift.erase_en && (cell_index >= shift.pos)
                       && ((index_wide + COUNT_BITS'(1)) < shift.count);

   // Next word of this cell.
   always_comb begin
      word_in = word_ff;
      if (shift.insert_en && at_pos) begin
         word_in = shift.value;
      end else if (take_lower) begin
         word_in = lower_word;
      end else if (take_upper) begin
         word_in = upper_word;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word      = word_ff;
   assign read_word = at_pos ? word_ff : '0;

endmodule

### design/indexed_list_buffer_core.sv
// A result item appears on rsp_payload with rsp_strobe in the cycle after start is taken.
// Throughput: one item per cycle; busy is high only during reset, since every command, insert
// and erase included, is carried out at once by the parallel-shifting row of entry cells.
// Reset (synchronous, active high) empties the list and clears the strobe; entry words
// are not cleared. The receiver cannot stall the result.
module indexed_list_buffer_core import ilb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_payload,
   output logic    rsp_strobe,
   output rsp_type rsp_payload
);

   logic                  accept;
   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;
   logic                  rsp_strobe_ff;
   rsp_type               rsp_ff;
   rsp_type               rsp_in;
   shift_type             shift;
   status_type            status;
   logic                  is_full;
   logic                  is_empty;
   logic                  read_ok;
   logic [WORD_BITS-1:0]  read_any;
   logic [WORD_BITS-1:0]  cell_word [CAPACITY];
   logic [WORD_BITS-1:0]  cell_read [CAPACITY];

   // No item is taken while reset is held.
   assign busy     = reset;
   assign accept   = start && !busy;
   assign is_full  = (count_ff == COUNT_BITS'(CAPACITY));
   assign is_empty = (count_ff == '0);

   // Decode the command, check bounds and set up the shift of the cell row.
   always_comb begin
      status          = ST_OK;
      count_in        = count_ff;
      read_ok         = 1'b0;
      shift.insert_en = 1'b0;
      shift.erase_en  = 1'b0;
      shift.pos       = req_payload.position;
      shift.count     = count_ff;
      shift.value     = req_payload.item_value;
      unique case (req_payload.command)
         CMD_PUSH: begin
            if (is_full) begin
               status = ST_FULL;
            end else begin
               // A push is an insert at the end of the list.
               shift.insert_en = accept;
               shift.pos       = count_ff[IDX_BITS-1:0];
               count_in        = count_ff + COUNT_BITS'(1);
            end
         end
         CMD_POP: begin
            if (is_empty) begin
               status = ST_EMPTY;
            end else begin
               count_in = count_ff - COUNT_BITS'(1);
            end
         end
         CMD_CLEAR: begin
            count_in = '0;
         end
         CMD_INSERT: begin
            if (is_full) begin
               status = ST_FULL;
            end else if (COUNT_BITS'(req_payload.position) > count_ff) begin
               status = ST_RANGE;
            end else begin
               shift.insert_en = accept;
               count_in        = count_ff + COUNT_BITS'(1);
            end
         end
         CMD_ERASE: begin
            if (is_empty) begin
               status = ST_EMPTY;
            end else if (COUNT_BITS'(req_payload.position) >= count_ff) begin
               status = ST_RANGE;
            end else begin
               shift.erase_en = accept;
               count_in       = count_ff - COUNT_BITS'(1);
            end
         end
         CMD_READ: begin
            if (COUNT_BITS'(req_payload.position) >= count_ff) begin
               status = ST_RANGE;
            end else begin
               read_ok = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Row of entry cells; each hands its word to both neighbors.
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [WORD_BITS-1:0] lower_word;
      logic [WORD_BITS-1:0] upper_word;
      if (g == 0) begin : g_first
         assign lower_word = '0;
      end else begin : g_lower
         assign lower_word = cell_word[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign upper_word = '0;
      end else begin : g_upper
         assign upper_word = cell_word[g+1];
      end
      ilb_cell u_cell (
         .clock      (clock),
         .cell_index (IDX_BITS'(g)),
         .shift      (shift),
         .lower_word (lower_word),
         .upper_word (upper_word),
         .word       (cell_word[g]),
         .read_word  (cell_read[g])
      );
   end

   // Only the cell at the position passes its word, so an OR collects the read.
   always_comb begin
      read_any = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         read_any = read_any | cell_read[i];
      end
   end

   // Assemble the result item.
   always_comb begin
      rsp_in.read_value  = read_ok ? read_any : '0;
      rsp_in.entry_count = count_in;
      rsp_in.status      = status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= accept;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

`ifndef NO_ASSERTIONS
   // Every accepted item yields a result in the next cycle.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe_ff)
      else $error("accepted item produced no result");

   // The list never holds more than its capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(CAPACITY))
      else $error("entry count beyond capacity");

   // The reported count matches the stored count.
   a_count_match: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> (rsp_ff.entry_count == count_ff))
      else $error("reported count differs from stored count");

   // A rejected command leaves the count unchanged.
   a_reject_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && (rsp_ff.status != ST_OK)) |-> (count_ff == $past(count_ff)))
      else $error("rejected command changed the count");

   // A rejected command returns a zero word.
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && (rsp_ff.status != ST_OK)) |-> (rsp_ff.read_value == '0))
      else $error("rejected command returned data");
`endif

endmodule

### tb/tb_indexed_list_buffer_core.sv
module tb_indexed_list_buffer_core;
   import ilb_pkg::*;

   // Command codes the block treats as no operation.
   localparam logic [2:0] CMD_SPARE_LO = 3'd6;
   localparam logic [2:0] CMD_SPARE_HI = 3'd7;

   // Sender idle rates, in percent, for the three random phases.
   localparam int unsigned IDLE_LIGHT = 8;
   localparam int unsigned IDLE_HEAVY = 72;
   localparam int unsigned IDLE_NONE  = 0;
   localparam int unsigned PHASE_ITEMS = 265;

   // Mirror of the list that predicts each result and checks it on arrival.
   class list_scoreboard;
      logic [WORD_BITS-1:0] cells [CAPACITY];
      int unsigned occupancy;
      rsp_type expected_results [$];
      int unsigned errors;
      int unsigned commands_seen;
      int unsigned status_seen [4];
      int unsigned full_hits;

      function new();
         occupancy = 0;
         errors = 0;
         commands_seen = 0;
         full_hits = 0;
         foreach (status_seen[k]) status_seen[k] = 0;
         foreach (cells[k]) cells[k] = '0;
      endfunction

      // Apply one accepted item to the mirror and queue the result it causes.
      function void record_command(req_type r);
         rsp_type e;
         int unsigned p;
         int unsigned i;
         e = '0;
         e.status = ST_OK;
         p = 32'(r.position);
         case (r.command)
            CMD_PUSH: begin
               if (occupancy >= CAPACITY) begin
                  e.status = ST_FULL;
               end else begin
                  cells[occupancy] = r.item_value;
                  occupancy++;
               end
            end
            CMD_POP: begin
               if (occupancy == 0) e.status = ST_EMPTY;
               else occupancy--;
            end
            CMD_CLEAR: occupancy = 0;
            CMD_INSERT: begin
               // A full list is reported before a bad index.
               if (occupancy >= CAPACITY) begin
                  e.status = ST_FULL;
               end else if (p > occupancy) begin
                  e.status = ST_RANGE;
               end else begin
                  for (i = occupancy; i > p; i--) cells[i] = cells[i-1];
                  cells[p] = r.item_value;
                  occupancy++;
               end
            end
            CMD_ERASE: begin
               if (occupancy == 0) begin
                  e.status = ST_EMPTY;
               end else if (p >= occupancy) begin
                  e.status = ST_RANGE;
               end else begin
                  for (i = p; i + 1 < occupancy; i++) cells[i] = cells[i+1];
                  occupancy--;
               end
            end
            CMD_READ: begin
               if (p >= occupancy) e.status = ST_RANGE;
               else e.read_value = cells[p];
            end
            default: ;
         endcase
         e.entry_count = COUNT_BITS'(occupancy);
         expected_results.insert(expected_results.size(), e);
         commands_seen++;
         status_seen[e.status]++;
         if (occupancy == CAPACITY) full_hits++;
      endfunction

      // Compare one result with the oldest prediction, field by field.
      function void check_result(rsp_type got);
         rsp_type e;
         if (expected_results.size() == 0) begin
            $display("%0t: result with no item pending: expected none, got %h",
                     $time, got);
            errors++;
            return;
         end
         e = expected_results.pop_front();
         if (got.read_value !== e.read_value) begin
            $display("%0t: read_value mismatch: expected %h, got %h",
                     $time, e.read_value, got.read_value);
            errors++;
         end
         if (got.entry_count !== e.entry_count) begin
            $display("%0t: entry_count mismatch: expected %0d, got %0d",
                     $time, e.entry_count, got.entry_count);
            errors++;
         end
         if (got.status !== e.status) begin
            $display("%0t: status mismatch: expected %0d, got %0d",
                     $time, e.status, got.status);
            errors++;
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_payload = '0;
   logic    rsp_strobe;
   rsp_type rsp_payload;

   list_scoreboard sb = new();
   bit growing = 1'b1;

   indexed_list_buffer_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   // Clock with a period of 10.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watch both channels; a result is checked before the item of the same edge is noted.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) sb.check_result(rsp_payload);
         if (start && !busy) sb.record_command(req_payload);
      end
   end

   // Offer one item after a random idle stretch and hold it until it is taken.
   task automatic send_command(logic [2:0] code, int unsigned pos,
                               logic [WORD_BITS-1:0] word, int unsigned idle_pct);
      req_type r;
      r.command = cmd_type'(code);
      r.position = IDX_BITS'(pos);
      r.item_value = word;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      req_payload <= r;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Data words lean toward the extremes now and then.
   function automatic logic [WORD_BITS-1:0] pick_word();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 8) return '0;
      if (roll < 16) return '1;
      return WORD_BITS'($urandom);
   endfunction

   // Random commands that swing the list between empty and full.
   task automatic run_random(int unsigned n, int unsigned idle_pct);
      int unsigned k;
      int unsigned occ;
      int unsigned roll;
      int unsigned sub;
      int unsigned pos;
      logic [2:0] code;
      for (k = 0; k < n; k++) begin
         occ = sb.occupancy;
         if (occ >= CAPACITY) growing = 1'b0;
         if (occ == 0) growing = 1'b1;
         if ($urandom_range(99) < 2) growing = !growing;
         roll = $urandom_range(99);
         sub = $urandom_range(99);
         if (roll < 3) begin
            code = ($urandom_range(1) == 0) ? CMD_SPARE_LO : CMD_SPARE_HI;
         end else if (roll < 5 && !growing) begin
            code = CMD_CLEAR;
         end else if (growing) begin
            code = (sub < 45) ? CMD_PUSH : (sub < 70) ? CMD_INSERT :
                   (sub < 80) ? CMD_READ : (sub < 90) ? CMD_POP : CMD_ERASE;
         end else begin
            code = (sub < 45) ? CMD_POP : (sub < 70) ? CMD_ERASE :
                   (sub < 80) ? CMD_READ : (sub < 90) ? CMD_PUSH : CMD_INSERT;
         end
         // Mostly legal indexes, some anywhere in the field.
         if ($urandom_range(99) < 15) pos = $urandom_range(CAPACITY - 1);
         else if (code == CMD_INSERT) pos = $urandom_range(occ);
         else if (occ > 0) pos = $urandom_range(occ - 1);
         else pos = $urandom_range(CAPACITY - 1);
         send_command(code, pos, pick_word(), idle_pct);
      end
   endtask

   initial begin
      int unsigned j;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty list errors, edge indexes, middle insert, append, no-ops, clear.
      send_command(CMD_POP,    0,  32'h0000_0000, IDLE_LIGHT);
      send_command(CMD_ERASE,  0,  32'h0000_0000, IDLE_LIGHT);
      send_command(CMD_READ,   0,  32'h0000_0000, IDLE_LIGHT);
      send_command(CMD_INSERT, 1,  32'h1111_1111, IDLE_LIGHT);
      send_command(CMD_INSERT, 0,  32'hFFFF_FFFF, IDLE_LIGHT);
      send_command(CMD_PUSH,   0,  32'h0000_0000, IDLE_LIGHT);
      send_command(CMD_PUSH,   63, 32'hA5A5_A5A5, IDLE_LIGHT);
      send_command(CMD_READ,   0,  32'h0000_0000, IDLE_LIGHT);
      send_command(CMD_READ,   2,  32'h0000_0000, IDLE_LIGHT);
      send_command(CMD_READ,   3,  32'h0000_0000, IDLE_LIGHT);
      send_command(CMD_READ,   63, 32'h0000_0000, IDLE_LIGHT);
      send_command(CMD_INSERT, 1,  32'h5A5A_5A5A, IDLE_LIGHT);
      send_command(CMD_INSERT, 4,  32'h1234_5678, IDLE_LIGHT);
      send_command(CMD_ERASE,  0,  32'h0000_0000, IDLE_LIGHT);
      send_command(CMD_ERASE,  63, 32'h0000_0000, IDLE_LIGHT);
      send_command(CMD_ERASE,  3,  32'h0000_0000, IDLE_LIGHT);
      send_command(CMD_POP,    0,  32'h0000_0000, IDLE_LIGHT);
      send_command(CMD_SPARE_LO, 5, 32'hDEAD_BEEF, IDLE_LIGHT);
      send_command(CMD_SPARE_HI, 62, 32'h0F0F_0F0F, IDLE_LIGHT);
      send_command(CMD_READ,   1,  32'h0000_0000, IDLE_LIGHT);
      send_command(CMD_CLEAR,  0,  32'h0000_0000, IDLE_LIGHT);
      send_command(CMD_READ,   0,  32'h0000_0000, IDLE_LIGHT);
      send_command(CMD_PUSH,   0,  32'h0000_0001, IDLE_LIGHT);

      // Fill past capacity, then hit the full and last-index cases.
      for (j = 0; j < CAPACITY; j++) send_command(CMD_PUSH, 0, pick_word(), IDLE_LIGHT);
      send_command(CMD_INSERT, 63, 32'h7777_7777, IDLE_LIGHT);
      send_command(CMD_INSERT, 5,  32'h8888_8888, IDLE_LIGHT);
      send_command(CMD_READ,   63, 32'h0000_0000, IDLE_LIGHT);
      send_command(CMD_ERASE,  63, 32'h0000_0000, IDLE_LIGHT);
      send_command(CMD_INSERT, 63, 32'h9999_9999, IDLE_LIGHT);
      send_command(CMD_ERASE,  0,  32'h0000_0000, IDLE_LIGHT);
      growing = 1'b0;

      run_random(PHASE_ITEMS, IDLE_LIGHT);
      run_random(PHASE_ITEMS, IDLE_HEAVY);
      run_random(PHASE_ITEMS, IDLE_NONE);
      start <= 1'b0;

      // Drain outstanding results, then wait for the last registered result to arrive.
      while (sb.expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("Checked %0d commands: %0d ok, %0d full, %0d empty, %0d out of range.",
               sb.commands_seen, sb.status_seen[ST_OK], sb.status_seen[ST_FULL],
               sb.status_seen[ST_EMPTY], sb.status_seen[ST_RANGE]);
      $display("The list held all %0d entries after %0d of them.", CAPACITY, sb.full_hits);
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Stop a hung run.
   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
